[rtl/core/ckc_pkg.sv]
// Package for the chroma key compositor: payload structs, key and threshold bundles,
// register indexes and fixed-point constants.
// Used by every module under rtl/core; depends on nothing.
package ckc_pkg;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Distance is sqrt(d2 * 65536); d2 needs 18 bits, the root 17 bits.
    localparam int D2_W        = 18;
    localparam int SQRT_STEPS  = 17;
    localparam int RAD_W       = 2 * SQRT_STEPS;
    localparam int DIST_W      = 17;
    localparam int SQRT_REM_W  = 18;
    localparam int ALPHA_W     = 17;
    localparam int DIV_STEPS   = 16;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] MAX_DIST = 17'd113068;
    localparam logic [16:0] MIN_RAMP = 17'd256;

    // floor(thr * 3 / 5) == (thr * 2516583) >> 22 for every 17-bit thr.
    localparam logic [21:0] NEAR_MUL = 22'd2516583;

    localparam logic [23:0] ROUND_HALF = 24'd32768;

    localparam logic [7:0]  KEY_RED_RST   = 8'd0;
    localparam logic [7:0]  KEY_GREEN_RST = 8'd255;
    localparam logic [7:0]  KEY_BLUE_RST  = 8'd0;
    localparam logic [16:0] KEY_THR_RST   = 17'd19661;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_RED       = 2'd0,
        REG_KEY_GREEN     = 2'd1,
        REG_KEY_BLUE      = 2'd2,
        REG_KEY_THRESHOLD = 2'd3
    } t_ckc_reg;

    typedef struct packed {
        logic [PIX_W-1:0] fg_red;
        logic [PIX_W-1:0] fg_green;
        logic [PIX_W-1:0] fg_blue;
        logic [PIX_W-1:0] bg_red;
        logic [PIX_W-1:0] bg_green;
        logic [PIX_W-1:0] bg_blue;
    } t_ckc_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } t_ckc_out;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_ckc_key;

    typedef struct packed {
        logic [DIST_W-1:0] t_near;
        logic [DIST_W-1:0] ramp;
    } t_ckc_thr;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[rtl/core/chroma_key_composite.sv]
// Chroma key compositor top level: configuration registers, distance, alpha and blend
// pipelines, and the output register with its skid stage. Depends on ckc_pkg.
//
// The block takes one foreground/background pixel pair per clock while o_in_ready is
// high and returns one composited pixel per request, in order. The pipelines are, in
// order: the channel difference register and the square-sum register, seventeen
// square-root stages (one distance bit each), seventeen alpha stages (the clamp and
// sixteen divider stages, one quotient bit each), the blend product and sum registers,
// and the output register. Every stage moves together; the pipeline halts only while
// the skid register holds a result, so the input stays ready while one finished result
// waits at the output. The key colour registers take effect for the next accepted
// request; the threshold register feeds three registered derivation steps that settle
// long before any request reaches the alpha stages. Registers are to be written only
// while the block holds no request in flight; the block itself does not enforce this.
module chroma_key_composite (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]    i_cfg_data,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ckc_pkg::t_ckc_in                  i_in_data,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ckc_pkg::t_ckc_out                 o_out_data
);

    ckc_pkg::t_ckc_key                  key;
    ckc_pkg::t_ckc_thr                  thr;

    logic                               pipe_en;

    logic                               dist_valid;
    ckc_pkg::t_ckc_in                   dist_pix;
    logic [ckc_pkg::DIST_W-1:0]         dist_val;

    logic                               alpha_valid;
    ckc_pkg::t_ckc_in                   alpha_pix;
    logic [ckc_pkg::ALPHA_W-1:0]        alpha_val;

    logic                               blend_valid;
    ckc_pkg::t_ckc_out                  blend_pix;

    logic                               r_out_valid;
    ckc_pkg::t_ckc_out                  r_out_pix;
    logic                               r_skid_valid;
    ckc_pkg::t_ckc_out                  r_skid_pix;
    logic                               out_free;

    // The whole pipeline advances whenever the skid register is empty.
    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;
    assign out_free   = !r_out_valid || i_out_ready;

    ckc_thresh u_thresh (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key),
        .o_thr       (thr)
    );

    ckc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_pix   (i_in_data),
        .i_key   (key),
        .o_valid (dist_valid),
        .o_pix   (dist_pix),
        .o_dist  (dist_val)
    );

    ckc_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (dist_valid),
        .i_pix   (dist_pix),
        .i_dist  (dist_val),
        .i_thr   (thr),
        .o_valid (alpha_valid),
        .o_pix   (alpha_pix),
        .o_alpha (alpha_val)
    );

    ckc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (alpha_valid),
        .i_pix   (alpha_pix),
        .i_alpha (alpha_val),
        .o_valid (blend_valid),
        .o_pix   (blend_pix)
    );

    // When the pipeline advances, its last result goes to the output register if
    // that register is free, and otherwise parks in the skid register. A parked
    // result moves to the output as soon as the output register frees up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pipe_en) begin
            if (out_free) begin
                r_out_valid <= blend_valid;
            end else if (blend_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (out_free) begin
                r_out_pix <= blend_pix;
            end else begin
                r_skid_pix <= blend_pix;
            end
        end else if (out_free) begin
            r_out_pix <= r_skid_pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_pix;

endmodule

[rtl/core/ckc_thresh.sv]
// Configuration registers of the chroma key compositor and the registered derivation
// of the near threshold and the alpha ramp width. Depends on ckc_pkg.
module ckc_thresh (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ckc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ckc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output ckc_pkg::t_ckc_key                   o_key,
    output ckc_pkg::t_ckc_thr                   o_thr
);

    logic [ckc_pkg::PIX_W-1:0]  r_key_red;
    logic [ckc_pkg::PIX_W-1:0]  r_key_green;
    logic [ckc_pkg::PIX_W-1:0]  r_key_blue;
    logic [ckc_pkg::THR_W-1:0]  r_key_thr;

    logic [ckc_pkg::THR_W-1:0]  r_far_q;
    logic [ckc_pkg::THR_W-1:0]  r_near_q;
    logic [ckc_pkg::DIST_W-1:0] r_t_far;
    logic [ckc_pkg::DIST_W-1:0] r_t_near;
    logic [ckc_pkg::DIST_W-1:0] r_ramp;

    logic [38:0]                n_near_prod;
    logic [ckc_pkg::THR_W-1:0]  n_near_raw;
    logic [33:0]                n_far_prod;
    logic [33:0]                n_tnear_prod;
    logic [ckc_pkg::DIST_W-1:0] n_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_red   <= ckc_pkg::KEY_RED_RST;
            r_key_green <= ckc_pkg::KEY_GREEN_RST;
            r_key_blue  <= ckc_pkg::KEY_BLUE_RST;
            r_key_thr   <= ckc_pkg::KEY_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ckc_pkg::REG_KEY_RED:       r_key_red   <= i_cfg_data[ckc_pkg::PIX_W-1:0];
                ckc_pkg::REG_KEY_GREEN:     r_key_green <= i_cfg_data[ckc_pkg::PIX_W-1:0];
                ckc_pkg::REG_KEY_BLUE:      r_key_blue  <= i_cfg_data[ckc_pkg::PIX_W-1:0];
                ckc_pkg::REG_KEY_THRESHOLD: r_key_thr   <= i_cfg_data[ckc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Near fraction is 3/5 of the threshold, done as a reciprocal multiply.
    always_comb begin
        n_near_prod  = r_key_thr * ckc_pkg::NEAR_MUL;
        n_near_raw   = n_near_prod[38:22];
        n_far_prod   = r_far_q * ckc_pkg::MAX_DIST;
        n_tnear_prod = r_near_q * ckc_pkg::MAX_DIST;
        n_span       = r_t_far - r_t_near;
    end

    always_ff @(posedge i_clk) begin
        r_far_q  <= (r_key_thr > ckc_pkg::ONE_Q16) ? ckc_pkg::ONE_Q16 : r_key_thr;
        r_near_q <= (n_near_raw > ckc_pkg::ONE_Q16) ? ckc_pkg::ONE_Q16 : n_near_raw;
        r_t_far  <= n_far_prod[32:16];
        r_t_near <= n_tnear_prod[32:16];
        r_ramp   <= (r_t_far > r_t_near && n_span >= ckc_pkg::MIN_RAMP) ?
                    n_span : ckc_pkg::MIN_RAMP;
    end

    assign o_key.red    = r_key_red;
    assign o_key.green  = r_key_green;
    assign o_key.blue   = r_key_blue;
    assign o_thr.t_near = r_t_near;
    assign o_thr.ramp   = r_ramp;

endmodule

[rtl/core/ckc_dist.sv]
// Distance pipeline: channel differences, sum of squares, then a restoring square root
// that resolves one result bit per stage. Depends on ckc_pkg.
module ckc_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ckc_pkg::t_ckc_in              i_pix,
    input  ckc_pkg::t_ckc_key             i_key,
    output logic                          o_valid,
    output ckc_pkg::t_ckc_in              o_pix,
    output logic [ckc_pkg::DIST_W-1:0]    o_dist
);

    localparam int N = ckc_pkg::SQRT_STEPS;

    logic                         r_a_valid;
    ckc_pkg::t_ckc_in             r_a_pix;
    logic [ckc_pkg::PIX_W-1:0]    r_a_dr;
    logic [ckc_pkg::PIX_W-1:0]    r_a_dg;
    logic [ckc_pkg::PIX_W-1:0]    r_a_db;

    logic [15:0]                  n_sq_r;
    logic [15:0]                  n_sq_g;
    logic [15:0]                  n_sq_b;
    logic [ckc_pkg::D2_W-1:0]     n_d2;

    logic                         r_s_valid [0:N];
    ckc_pkg::t_ckc_in             r_s_pix   [0:N];
    logic [ckc_pkg::D2_W-1:0]     r_s_d2    [0:N];
    logic [ckc_pkg::SQRT_REM_W-1:0] r_s_rem [0:N];
    logic [ckc_pkg::DIST_W-1:0]   r_s_root  [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pix <= i_pix;
            r_a_dr  <= ckc_pkg::abs_diff(i_pix.fg_red, i_key.red);
            r_a_dg  <= ckc_pkg::abs_diff(i_pix.fg_green, i_key.green);
            r_a_db  <= ckc_pkg::abs_diff(i_pix.fg_blue, i_key.blue);
        end
    end

    always_comb begin
        n_sq_r = r_a_dr * r_a_dr;
        n_sq_g = r_a_dg * r_a_dg;
        n_sq_b = r_a_db * r_a_db;
        n_d2   = {2'b00, n_sq_r} + {2'b00, n_sq_g} + {2'b00, n_sq_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_s_valid[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_pix[0]  <= r_a_pix;
            r_s_d2[0]   <= n_d2;
            r_s_rem[0]  <= '0;
            r_s_root[0] <= '0;
        end
    end

    // The radicand is d2 followed by sixteen zero bits; stage k takes bit pair N-1-k.
    for (genvar k = 0; k < N; k++) begin : g_sqrt
        localparam int P = N - 1 - k;
        logic [ckc_pkg::RAD_W-1:0]        rad;
        logic [ckc_pkg::SQRT_REM_W+1:0]   rem_sh;
        logic [ckc_pkg::SQRT_REM_W+1:0]   trial;
        logic [ckc_pkg::SQRT_REM_W+1:0]   rem_sub;
        logic                             take;

        assign rad     = {r_s_d2[k], 16'b0};
        assign rem_sh  = {r_s_rem[k], rad[2*P+1 -: 2]};
        assign trial   = {1'b0, r_s_root[k], 2'b01};
        assign take    = rem_sh >= trial;
        assign rem_sub = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_s_valid[k+1] <= r_s_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s_pix[k+1]  <= r_s_pix[k];
                r_s_d2[k+1]   <= r_s_d2[k];
                r_s_rem[k+1]  <= take ? rem_sub[ckc_pkg::SQRT_REM_W-1:0]
                                      : rem_sh[ckc_pkg::SQRT_REM_W-1:0];
                r_s_root[k+1] <= {r_s_root[k][ckc_pkg::DIST_W-2:0], take};
            end
        end
    end

    assign o_valid = r_s_valid[N];
    assign o_pix   = r_s_pix[N];
    assign o_dist  = r_s_root[N];

endmodule

[rtl/core/ckc_alpha.sv]
// Alpha pipeline: offset of the distance past the near threshold, clamping, and a
// restoring divider by the ramp width that yields one quotient bit per stage.
// Depends on ckc_pkg.
module ckc_alpha (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ckc_pkg::t_ckc_in              i_pix,
    input  logic [ckc_pkg::DIST_W-1:0]    i_dist,
    input  ckc_pkg::t_ckc_thr             i_thr,
    output logic                          o_valid,
    output ckc_pkg::t_ckc_in              o_pix,
    output logic [ckc_pkg::ALPHA_W-1:0]   o_alpha
);

    localparam int N = ckc_pkg::DIV_STEPS;
    localparam int W = ckc_pkg::DIST_W;

    logic [W-1:0]           n_diff;
    logic                   n_above;

    logic                   r_d_valid [0:N];
    ckc_pkg::t_ckc_in       r_d_pix   [0:N];
    logic [W-1:0]           r_d_rem   [0:N];
    logic [N-1:0]           r_d_quot  [0:N];
    logic                   r_d_zero  [0:N];
    logic                   r_d_full  [0:N];

    always_comb begin
        n_above = i_dist > i_thr.t_near;
        n_diff  = i_dist - i_thr.t_near;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_d_valid[0] <= i_valid;
        end
    end

    // Once the offset reaches the ramp width the quotient is at least one: alpha is full.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_pix[0]  <= i_pix;
            r_d_rem[0]  <= n_diff;
            r_d_quot[0] <= '0;
            r_d_zero[0] <= !n_above;
            r_d_full[0] <= n_above && (n_diff >= i_thr.ramp);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [W:0] rem_sh;
        logic [W:0] rem_sub;
        logic       take;

        assign rem_sh  = {r_d_rem[k], 1'b0};
        assign take    = rem_sh >= {1'b0, i_thr.ramp};
        assign rem_sub = rem_sh - {1'b0, i_thr.ramp};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_d_valid[k+1] <= r_d_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d_pix[k+1]  <= r_d_pix[k];
                r_d_rem[k+1]  <= take ? rem_sub[W-1:0] : rem_sh[W-1:0];
                r_d_quot[k+1] <= {r_d_quot[k][N-2:0], take};
                r_d_zero[k+1] <= r_d_zero[k];
                r_d_full[k+1] <= r_d_full[k];
            end
        end
    end

    assign o_valid = r_d_valid[N];
    assign o_pix   = r_d_pix[N];
    assign o_alpha = r_d_zero[N] ? '0 :
                     r_d_full[N] ? ckc_pkg::ONE_Q16 : {1'b0, r_d_quot[N]};

endmodule

[rtl/core/ckc_blend.sv]
// Blend pipeline: per-channel products with alpha and its complement, then the
// rounded sum scaled back to eight bits. Depends on ckc_pkg.
module ckc_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ckc_pkg::t_ckc_in              i_pix,
    input  logic [ckc_pkg::ALPHA_W-1:0]   i_alpha,
    output logic                          o_valid,
    output ckc_pkg::t_ckc_out             o_pix
);

    localparam int PW = ckc_pkg::PIX_W + ckc_pkg::ALPHA_W;

    logic [ckc_pkg::PIX_W-1:0]   n_fg [0:2];
    logic [ckc_pkg::PIX_W-1:0]   n_bg [0:2];
    logic [ckc_pkg::ALPHA_W-1:0] n_beta;
    logic [PW-1:0]               n_pf [0:2];
    logic [PW-1:0]               n_pb [0:2];
    logic [PW:0]                 n_sum [0:2];

    logic                        r_p_valid;
    logic [PW-1:0]               r_pf [0:2];
    logic [PW-1:0]               r_pb [0:2];
    logic                        r_o_valid;
    ckc_pkg::t_ckc_out           r_o_pix;

    always_comb begin
        n_fg[0] = i_pix.fg_red;
        n_fg[1] = i_pix.fg_green;
        n_fg[2] = i_pix.fg_blue;
        n_bg[0] = i_pix.bg_red;
        n_bg[1] = i_pix.bg_green;
        n_bg[2] = i_pix.bg_blue;
        n_beta  = ckc_pkg::ONE_Q16 - i_alpha;
        for (int c = 0; c < 3; c++) begin
            n_pf[c] = n_fg[c] * i_alpha;
            n_pb[c] = n_bg[c] * n_beta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_pf[c] <= n_pf[c];
                r_pb[c] <= n_pb[c];
            end
        end
    end

    // The rounded sum stays below 2^24, so bits 23:16 hold the channel.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = {1'b0, r_pf[c]} + {1'b0, r_pb[c]} + {2'b00, ckc_pkg::ROUND_HALF};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_pix.out_red   <= n_sum[0][23:16];
            r_o_pix.out_green <= n_sum[1][23:16];
            r_o_pix.out_blue  <= n_sum[2][23:16];
        end
    end

    assign o_valid = r_o_valid;
    assign o_pix   = r_o_pix;

endmodule
